@@ hw/rtl/qro_pkg.sv @@
// qro_pkg: shared constants and types for the quad / rectangle overlap test.
// No dependencies.
`default_nettype none

package qro_pkg;

  localparam int NUM_CORNERS = 4;  // corners of each shape
  localparam int NUM_QAXES   = 2;  // axes taken from quad edges
  localparam int NUM_REDGES  = 2;  // distinct rectangle edge coordinates per dimension

  // Separation already decided on the two rectangle axes
  typedef struct packed {
    logic sep_w;  // x intervals apart, width nonzero
    logic sep_h;  // y intervals apart, height nonzero
  } rect_sep_t;

endpackage

`default_nettype wire

@@ hw/rtl/qro_if.sv @@
// qro_if: valid/ready channel interfaces for shape pairs and overlap results.
// No dependencies.
`default_nettype none

interface qro_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] quad_x0;
  logic signed [COORD_BITS-1:0] quad_y0;
  logic signed [COORD_BITS-1:0] quad_x1;
  logic signed [COORD_BITS-1:0] quad_y1;
  logic signed [COORD_BITS-1:0] quad_x2;
  logic signed [COORD_BITS-1:0] quad_y2;
  logic signed [COORD_BITS-1:0] quad_x3;
  logic signed [COORD_BITS-1:0] quad_y3;
  logic signed [COORD_BITS-1:0] rect_left;
  logic signed [COORD_BITS-1:0] rect_top;
  logic        [COORD_BITS-2:0] rect_width;
  logic        [COORD_BITS-2:0] rect_height;

  modport source (
    output valid, quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
    output rect_left, rect_top, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, quad_x0, quad_y0, quad_x1, quad_y1, quad_x2, quad_y2, quad_x3, quad_y3,
    input  rect_left, rect_top, rect_width, rect_height,
    output ready
  );
endinterface

interface qro_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/quad_rect_overlap_sat.sv @@
// quad_rect_overlap_sat: separating axis overlap test, quad vs axis-aligned rectangle.
// Depends on qro_pkg, qro_if, qro_front, qro_proj and qro_sep.
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid / ready | four quad corners, rect left, top, width, height
//   out_ch  | out | valid / ready | overlap
//
// One transaction per cycle sustained while out_ch is not stalled; after acceptance the result passes
// through the input register, setup, products, dot sums, intervals and result register.
// The depth is set by the 24 parallel coordinate multipliers, each followed by a register.
// Every stage has its own valid bit and moves whenever the stage after it is free,
// so a stalled output only backs up as far as the pipeline is full.
// rst_n (synchronous) clears the valid bits only.
`default_nettype none

module quad_rect_overlap_sat #(
  parameter int COORD_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qro_in_if.sink    in_ch,
  qro_out_if.source out_ch
);

  logic                          s1_valid, s1_ready;
  logic signed [COORD_BITS:0]    ax [qro_pkg::NUM_QAXES];
  logic signed [COORD_BITS:0]    ay [qro_pkg::NUM_QAXES];
  logic signed [COORD_BITS:0]    qx [qro_pkg::NUM_CORNERS];
  logic signed [COORD_BITS:0]    qy [qro_pkg::NUM_CORNERS];
  logic signed [COORD_BITS:0]    rx [qro_pkg::NUM_REDGES];
  logic signed [COORD_BITS:0]    ry [qro_pkg::NUM_REDGES];
  qro_pkg::rect_sep_t            rsep1;

  logic                          s3_valid, s3_ready;
  logic signed [2*COORD_BITS+2:0] dq [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [2*COORD_BITS+2:0] dr [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  qro_pkg::rect_sep_t            rsep3;

  qro_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .ax_o     (ax),
    .ay_o     (ay),
    .qx_o     (qx),
    .qy_o     (qy),
    .rx_o     (rx),
    .ry_o     (ry),
    .rsep_o   (rsep1)
  );

  qro_proj #(
    .COORD_BITS (COORD_BITS)
  ) u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .ax_i     (ax),
    .ay_i     (ay),
    .qx_i     (qx),
    .qy_i     (qy),
    .rx_i     (rx),
    .ry_i     (ry),
    .rsep_i   (rsep1),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .dq_o     (dq),
    .dr_o     (dr),
    .rsep_o   (rsep3)
  );

  qro_sep #(
    .COORD_BITS (COORD_BITS)
  ) u_sep (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .dq_i     (dq),
    .dr_i     (dr),
    .rsep_i   (rsep3),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ hw/rtl/qro_front.sv @@
// qro_front: input register, then axes, rectangle edges and the rectangle-axis tests.
// Depends on qro_pkg and qro_in_if.
`default_nettype none

module qro_front #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  qro_in_if.sink                       in_ch,
  output logic                         s1_valid,
  input  wire logic                    s1_ready,
  output logic signed [COORD_BITS:0]   ax_o [qro_pkg::NUM_QAXES],
  output logic signed [COORD_BITS:0]   ay_o [qro_pkg::NUM_QAXES],
  output logic signed [COORD_BITS:0]   qx_o [qro_pkg::NUM_CORNERS],
  output logic signed [COORD_BITS:0]   qy_o [qro_pkg::NUM_CORNERS],
  output logic signed [COORD_BITS:0]   rx_o [qro_pkg::NUM_REDGES],
  output logic signed [COORD_BITS:0]   ry_o [qro_pkg::NUM_REDGES],
  output qro_pkg::rect_sep_t           rsep_o
);

  localparam int EW = COORD_BITS + 1;

  // stage 0: raw transaction
  logic                         s0_v_r;
  logic signed [COORD_BITS-1:0] qx_in_r [qro_pkg::NUM_CORNERS];
  logic signed [COORD_BITS-1:0] qy_in_r [qro_pkg::NUM_CORNERS];
  logic signed [COORD_BITS-1:0] left_r;
  logic signed [COORD_BITS-1:0] top_r;
  logic        [COORD_BITS-2:0] w_r;
  logic        [COORD_BITS-2:0] h_r;

  // stage 1
  logic                s1_v_r;
  logic signed [EW-1:0] ax_r [qro_pkg::NUM_QAXES];
  logic signed [EW-1:0] ay_r [qro_pkg::NUM_QAXES];
  logic signed [EW-1:0] qx_r [qro_pkg::NUM_CORNERS];
  logic signed [EW-1:0] qy_r [qro_pkg::NUM_CORNERS];
  logic signed [EW-1:0] rx_r [qro_pkg::NUM_REDGES];
  logic signed [EW-1:0] ry_r [qro_pkg::NUM_REDGES];
  qro_pkg::rect_sep_t   rsep_r;

  logic signed [EW-1:0] ax_nxt [qro_pkg::NUM_QAXES];
  logic signed [EW-1:0] ay_nxt [qro_pkg::NUM_QAXES];
  logic signed [EW-1:0] qx_nxt [qro_pkg::NUM_CORNERS];
  logic signed [EW-1:0] qy_nxt [qro_pkg::NUM_CORNERS];
  logic signed [EW-1:0] rx_nxt [qro_pkg::NUM_REDGES];
  logic signed [EW-1:0] ry_nxt [qro_pkg::NUM_REDGES];
  qro_pkg::rect_sep_t   rsep_nxt;

  logic signed [EW-1:0] qx_min, qx_max, qy_min, qy_max;
  logic                 s0_rdy, s1_rdy;

  function automatic logic signed [EW-1:0] min4(
    input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
    input logic signed [EW-1:0] c, input logic signed [EW-1:0] d
  );
    logic signed [EW-1:0] ab, cd;
    ab = (a < b) ? a : b;
    cd = (c < d) ? c : d;
    return (ab < cd) ? ab : cd;
  endfunction

  function automatic logic signed [EW-1:0] max4(
    input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
    input logic signed [EW-1:0] c, input logic signed [EW-1:0] d
  );
    logic signed [EW-1:0] ab, cd;
    ab = (a > b) ? a : b;
    cd = (c > d) ? c : d;
    return (ab > cd) ? ab : cd;
  endfunction

  assign s1_rdy      = !s1_v_r || s1_ready;
  assign s0_rdy      = !s0_v_r || s1_rdy;
  assign in_ch.ready = s0_rdy;

  always_comb begin
    for (int i = 0; i < qro_pkg::NUM_CORNERS; i++) begin
      qx_nxt[i] = {qx_in_r[i][COORD_BITS-1], qx_in_r[i]};
      qy_nxt[i] = {qy_in_r[i][COORD_BITS-1], qy_in_r[i]};
    end
    // rectangle spans [left, left+w] x [top, top+h]
    rx_nxt[0] = {left_r[COORD_BITS-1], left_r};
    rx_nxt[1] = rx_nxt[0] + $signed({2'b00, w_r});
    ry_nxt[0] = {top_r[COORD_BITS-1], top_r};
    ry_nxt[1] = ry_nxt[0] + $signed({2'b00, h_r});
    // quad edges from corner 0 to corners 1 and 3
    ax_nxt[0] = qx_nxt[1] - qx_nxt[0];
    ay_nxt[0] = qy_nxt[1] - qy_nxt[0];
    ax_nxt[1] = qx_nxt[3] - qx_nxt[0];
    ay_nxt[1] = qy_nxt[3] - qy_nxt[0];

    qx_min = min4(qx_nxt[0], qx_nxt[1], qx_nxt[2], qx_nxt[3]);
    qx_max = max4(qx_nxt[0], qx_nxt[1], qx_nxt[2], qx_nxt[3]);
    qy_min = min4(qy_nxt[0], qy_nxt[1], qy_nxt[2], qy_nxt[3]);
    qy_max = max4(qy_nxt[0], qy_nxt[1], qy_nxt[2], qy_nxt[3]);

    // rectangle axes scale x or y by a nonnegative size: a plain interval
    // test, unless the size is zero and the axis collapses
    rsep_nxt.sep_w = (w_r != '0) && ((rx_nxt[0] > qx_max) || (qx_min > rx_nxt[1]));
    rsep_nxt.sep_h = (h_r != '0) && ((ry_nxt[0] > qy_max) || (qy_min > ry_nxt[1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (s0_rdy) begin
        s0_v_r <= in_ch.valid;
      end
      if (s1_rdy) begin
        s1_v_r <= s0_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_ch.valid) begin
      qx_in_r[0] <= in_ch.quad_x0;
      qy_in_r[0] <= in_ch.quad_y0;
      qx_in_r[1] <= in_ch.quad_x1;
      qy_in_r[1] <= in_ch.quad_y1;
      qx_in_r[2] <= in_ch.quad_x2;
      qy_in_r[2] <= in_ch.quad_y2;
      qx_in_r[3] <= in_ch.quad_x3;
      qy_in_r[3] <= in_ch.quad_y3;
      left_r     <= in_ch.rect_left;
      top_r      <= in_ch.rect_top;
      w_r        <= in_ch.rect_width;
      h_r        <= in_ch.rect_height;
    end
    if (s1_rdy && s0_v_r) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      rsep_r <= rsep_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign ax_o     = ax_r;
  assign ay_o     = ay_r;
  assign qx_o     = qx_r;
  assign qy_o     = qy_r;
  assign rx_o     = rx_r;
  assign ry_o     = ry_r;
  assign rsep_o   = rsep_r;

endmodule

`default_nettype wire

@@ hw/rtl/qro_proj.sv @@
// qro_proj: projects both shapes onto the two quad-edge axes (products, then dot sums).
// Depends on qro_pkg.
`default_nettype none

module qro_proj #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_valid,
  output logic                             s1_ready,
  input  wire logic signed [COORD_BITS:0]  ax_i [qro_pkg::NUM_QAXES],
  input  wire logic signed [COORD_BITS:0]  ay_i [qro_pkg::NUM_QAXES],
  input  wire logic signed [COORD_BITS:0]  qx_i [qro_pkg::NUM_CORNERS],
  input  wire logic signed [COORD_BITS:0]  qy_i [qro_pkg::NUM_CORNERS],
  input  wire logic signed [COORD_BITS:0]  rx_i [qro_pkg::NUM_REDGES],
  input  wire logic signed [COORD_BITS:0]  ry_i [qro_pkg::NUM_REDGES],
  input  wire qro_pkg::rect_sep_t          rsep_i,
  output logic                             s3_valid,
  input  wire logic                        s3_ready,
  output logic signed [2*COORD_BITS+2:0]   dq_o [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS],
  output logic signed [2*COORD_BITS+2:0]   dr_o [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS],
  output qro_pkg::rect_sep_t               rsep_o
);

  localparam int PW = 2 * COORD_BITS + 2;  // exact product width
  localparam int DW = PW + 1;              // exact dot product width

  // stage 2: products; rectangle terms are shared between its corners
  logic                 s2_v_r;
  logic signed [PW-1:0] pqx_r [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [PW-1:0] pqy_r [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [PW-1:0] prx_r [qro_pkg::NUM_QAXES][qro_pkg::NUM_REDGES];
  logic signed [PW-1:0] pry_r [qro_pkg::NUM_QAXES][qro_pkg::NUM_REDGES];
  qro_pkg::rect_sep_t   rsep2_r;

  logic signed [PW-1:0] pqx_nxt [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [PW-1:0] pqy_nxt [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [PW-1:0] prx_nxt [qro_pkg::NUM_QAXES][qro_pkg::NUM_REDGES];
  logic signed [PW-1:0] pry_nxt [qro_pkg::NUM_QAXES][qro_pkg::NUM_REDGES];

  // stage 3: dot products
  logic                 s3_v_r;
  logic signed [DW-1:0] dq_r [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [DW-1:0] dr_r [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  qro_pkg::rect_sep_t   rsep3_r;

  logic signed [DW-1:0] dq_nxt [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];
  logic signed [DW-1:0] dr_nxt [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS];

  logic s2_rdy, s3_rdy;

  assign s3_rdy   = !s3_v_r || s3_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_ready = s2_rdy;

  always_comb begin
    for (int k = 0; k < qro_pkg::NUM_QAXES; k++) begin
      for (int i = 0; i < qro_pkg::NUM_CORNERS; i++) begin
        pqx_nxt[k][i] = PW'(ax_i[k]) * PW'(qx_i[i]);
        pqy_nxt[k][i] = PW'(ay_i[k]) * PW'(qy_i[i]);
      end
      for (int j = 0; j < qro_pkg::NUM_REDGES; j++) begin
        prx_nxt[k][j] = PW'(ax_i[k]) * PW'(rx_i[j]);
        pry_nxt[k][j] = PW'(ay_i[k]) * PW'(ry_i[j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < qro_pkg::NUM_QAXES; k++) begin
      for (int i = 0; i < qro_pkg::NUM_CORNERS; i++) begin
        dq_nxt[k][i] = DW'(pqx_r[k][i]) + DW'(pqy_r[k][i]);
      end
      // corners: left/bottom, left/top, right/top, right/bottom
      dr_nxt[k][0] = DW'(prx_r[k][0]) + DW'(pry_r[k][1]);
      dr_nxt[k][1] = DW'(prx_r[k][0]) + DW'(pry_r[k][0]);
      dr_nxt[k][2] = DW'(prx_r[k][1]) + DW'(pry_r[k][0]);
      dr_nxt[k][3] = DW'(prx_r[k][1]) + DW'(pry_r[k][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_v_r <= s1_valid;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid) begin
      pqx_r   <= pqx_nxt;
      pqy_r   <= pqy_nxt;
      prx_r   <= prx_nxt;
      pry_r   <= pry_nxt;
      rsep2_r <= rsep_i;
    end
    if (s3_rdy && s2_v_r) begin
      dq_r    <= dq_nxt;
      dr_r    <= dr_nxt;
      rsep3_r <= rsep2_r;
    end
  end

  assign s3_valid = s3_v_r;
  assign dq_o     = dq_r;
  assign dr_o     = dr_r;
  assign rsep_o   = rsep3_r;

endmodule

`default_nettype wire

@@ hw/rtl/qro_sep.sv @@
// qro_sep: projection intervals per axis, gap test and the result register.
// Depends on qro_pkg and qro_out_if.
`default_nettype none

module qro_sep #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s3_valid,
  output logic                               s3_ready,
  input  wire logic signed [2*COORD_BITS+2:0] dq_i [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS],
  input  wire logic signed [2*COORD_BITS+2:0] dr_i [qro_pkg::NUM_QAXES][qro_pkg::NUM_CORNERS],
  input  wire qro_pkg::rect_sep_t            rsep_i,
  qro_out_if.source                          out_ch
);

  localparam int DW = 2 * COORD_BITS + 3;

  // stage 4: intervals
  logic                 s4_v_r;
  logic signed [DW-1:0] qmin_r [qro_pkg::NUM_QAXES];
  logic signed [DW-1:0] qmax_r [qro_pkg::NUM_QAXES];
  logic signed [DW-1:0] rmin_r [qro_pkg::NUM_QAXES];
  logic signed [DW-1:0] rmax_r [qro_pkg::NUM_QAXES];
  qro_pkg::rect_sep_t   rsep_r;

  logic signed [DW-1:0] qmin_nxt [qro_pkg::NUM_QAXES];
  logic signed [DW-1:0] qmax_nxt [qro_pkg::NUM_QAXES];
  logic signed [DW-1:0] rmin_nxt [qro_pkg::NUM_QAXES];
  logic signed [DW-1:0] rmax_nxt [qro_pkg::NUM_QAXES];

  // stage 5: result register
  logic out_v_r;
  logic overlap_r;
  logic overlap_nxt;
  logic s4_rdy, s5_rdy;

  function automatic logic signed [DW-1:0] min4(
    input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
    input logic signed [DW-1:0] c, input logic signed [DW-1:0] d
  );
    logic signed [DW-1:0] ab, cd;
    ab = (a < b) ? a : b;
    cd = (c < d) ? c : d;
    return (ab < cd) ? ab : cd;
  endfunction

  function automatic logic signed [DW-1:0] max4(
    input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
    input logic signed [DW-1:0] c, input logic signed [DW-1:0] d
  );
    logic signed [DW-1:0] ab, cd;
    ab = (a > b) ? a : b;
    cd = (c > d) ? c : d;
    return (ab > cd) ? ab : cd;
  endfunction

  assign s5_rdy   = !out_v_r || out_ch.ready;
  assign s4_rdy   = !s4_v_r || s5_rdy;
  assign s3_ready = s4_rdy;

  always_comb begin
    for (int k = 0; k < qro_pkg::NUM_QAXES; k++) begin
      qmin_nxt[k] = min4(dq_i[k][0], dq_i[k][1], dq_i[k][2], dq_i[k][3]);
      qmax_nxt[k] = max4(dq_i[k][0], dq_i[k][1], dq_i[k][2], dq_i[k][3]);
      rmin_nxt[k] = min4(dr_i[k][0], dr_i[k][1], dr_i[k][2], dr_i[k][3]);
      rmax_nxt[k] = max4(dr_i[k][0], dr_i[k][1], dr_i[k][2], dr_i[k][3]);
    end
  end

  // touching intervals (zero gap) do not separate
  always_comb begin
    overlap_nxt = !(rsep_r.sep_w || rsep_r.sep_h);
    for (int k = 0; k < qro_pkg::NUM_QAXES; k++) begin
      if ((rmin_r[k] > qmax_r[k]) || (qmin_r[k] > rmax_r[k])) begin
        overlap_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s4_rdy) begin
        s4_v_r <= s3_valid;
      end
      if (s5_rdy) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_valid) begin
      qmin_r <= qmin_nxt;
      qmax_r <= qmax_nxt;
      rmin_r <= rmin_nxt;
      rmax_r <= rmax_nxt;
      rsep_r <= rsep_i;
    end
    if (s5_rdy && s4_v_r) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.overlap = overlap_r;

endmodule

`default_nettype wire
